// ===== rtl/qau_pkg.sv =====
`timescale 1ns / 1ps

package qau_pkg;

  // component and arithmetic widths
  localparam int unsigned QW      = 32;          // Q16.16 component
  localparam int unsigned FRAC    = 16;          // fraction bits
  localparam int unsigned PROD_W  = 2 * QW;      // exact product
  localparam int unsigned SUM_W   = PROD_W + 2;  // exact sum of four products
  localparam int unsigned RND_W   = SUM_W - FRAC;// rounded sum
  localparam int unsigned LIN_W   = QW + 1;      // exact sum or difference
  localparam int unsigned N_LANES = 4;           // w, x, y, z
  localparam int unsigned N_TERMS = 4;           // products per component

  localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_HAM   = 3'd2,
    OP_SCALE = 3'd3,
    OP_CONJ  = 3'd4
  } op_e;

  // operands for one lane: four multiplier pairs or one linear value
  typedef struct packed {
    logic [N_TERMS-1:0][QW-1:0] m_a;
    logic [N_TERMS-1:0][QW-1:0] m_b;
    logic [N_TERMS-1:0]         neg;
    logic                       prod_mode;
    logic [LIN_W-1:0]           lin;
  } lane_op_t;

  typedef lane_op_t [N_LANES-1:0] lane_ops_t;

  typedef logic [N_LANES-1:0][RND_W-1:0] lane_vals_t;

endpackage

// ===== rtl/qau_route.sv =====
`timescale 1ns / 1ps

module qau_route (
  input  logic [2:0]                                       opcode_i,
  input  logic [qau_pkg::N_LANES-1:0][qau_pkg::QW-1:0]     a_i,
  input  logic [qau_pkg::N_LANES-1:0][qau_pkg::QW-1:0]     b_i,
  input  logic [qau_pkg::QW-1:0]                           factor_i,
  output qau_pkg::lane_ops_t                               lanes_o
);

  logic signed [qau_pkg::QW-1:0] a [qau_pkg::N_LANES];
  logic signed [qau_pkg::QW-1:0] b [qau_pkg::N_LANES];

  always_comb begin
    for (int c = 0; c < qau_pkg::N_LANES; c++) begin
      a[c] = $signed(a_i[c]);
      b[c] = $signed(b_i[c]);
    end
  end

  always_comb begin
    lanes_o = '0;
    unique case (qau_pkg::op_e'(opcode_i))
      qau_pkg::OP_ADD: begin
        for (int c = 0; c < qau_pkg::N_LANES; c++) begin
          lanes_o[c].lin = qau_pkg::LIN_W'(a[c]) + qau_pkg::LIN_W'(b[c]);
        end
      end
      qau_pkg::OP_SUB: begin
        for (int c = 0; c < qau_pkg::N_LANES; c++) begin
          lanes_o[c].lin = qau_pkg::LIN_W'(a[c]) - qau_pkg::LIN_W'(b[c]);
        end
      end
      qau_pkg::OP_HAM: begin
        // w = aw*bw - ax*bx - ay*by - az*bz
        lanes_o[0].m_a[0] = a[0]; lanes_o[0].m_b[0] = b[0];
        lanes_o[0].m_a[1] = a[1]; lanes_o[0].m_b[1] = b[1];
        lanes_o[0].m_a[2] = a[2]; lanes_o[0].m_b[2] = b[2];
        lanes_o[0].m_a[3] = a[3]; lanes_o[0].m_b[3] = b[3];
        lanes_o[0].neg    = 4'b1110;
        // x = aw*bx + bw*ax + ay*bz - by*az
        lanes_o[1].m_a[0] = a[0]; lanes_o[1].m_b[0] = b[1];
        lanes_o[1].m_a[1] = b[0]; lanes_o[1].m_b[1] = a[1];
        lanes_o[1].m_a[2] = a[2]; lanes_o[1].m_b[2] = b[3];
        lanes_o[1].m_a[3] = b[2]; lanes_o[1].m_b[3] = a[3];
        lanes_o[1].neg    = 4'b1000;
        // y = aw*by + bw*ay + az*bx - bz*ax
        lanes_o[2].m_a[0] = a[0]; lanes_o[2].m_b[0] = b[2];
        lanes_o[2].m_a[1] = b[0]; lanes_o[2].m_b[1] = a[2];
        lanes_o[2].m_a[2] = a[3]; lanes_o[2].m_b[2] = b[1];
        lanes_o[2].m_a[3] = b[3]; lanes_o[2].m_b[3] = a[1];
        lanes_o[2].neg    = 4'b1000;
        // z = aw*bz + bw*az + ax*by - bx*ay
        lanes_o[3].m_a[0] = a[0]; lanes_o[3].m_b[0] = b[3];
        lanes_o[3].m_a[1] = b[0]; lanes_o[3].m_b[1] = a[3];
        lanes_o[3].m_a[2] = a[1]; lanes_o[3].m_b[2] = b[2];
        lanes_o[3].m_a[3] = b[1]; lanes_o[3].m_b[3] = a[2];
        lanes_o[3].neg    = 4'b1000;
        for (int c = 0; c < qau_pkg::N_LANES; c++) begin
          lanes_o[c].prod_mode = 1'b1;
        end
      end
      qau_pkg::OP_SCALE: begin
        for (int c = 0; c < qau_pkg::N_LANES; c++) begin
          lanes_o[c].m_a[0]    = a[c];
          lanes_o[c].m_b[0]    = factor_i;
          lanes_o[c].prod_mode = 1'b1;
        end
      end
      qau_pkg::OP_CONJ: begin
        // times -1.0 in Q16.16 rounds back to the exact negation
        lanes_o[0].lin = qau_pkg::LIN_W'(a[0]);
        for (int c = 1; c < qau_pkg::N_LANES; c++) begin
          lanes_o[c].lin = -qau_pkg::LIN_W'(a[c]);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/qau_lane.sv =====
`timescale 1ns / 1ps

module qau_lane (
  input  logic                              clk_i,
  input  logic                              mul_en_i,
  input  logic                              sum_en_i,
  input  qau_pkg::lane_op_t                 op_i,
  output logic [qau_pkg::RND_W-1:0]         val_o
);

  logic signed [qau_pkg::PROD_W-1:0] prod_q [qau_pkg::N_TERMS];
  logic [qau_pkg::N_TERMS-1:0]       neg_q;
  logic                              prod_mode_q;
  logic signed [qau_pkg::LIN_W-1:0]  lin_q;

  logic signed [qau_pkg::SUM_W-1:0]  sum;
  logic signed [qau_pkg::SUM_W-1:0]  sum_rnd;
  logic [qau_pkg::RND_W-1:0]         val_d;
  logic [qau_pkg::RND_W-1:0]         val_q;

  // stage 1: exact products
  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      for (int t = 0; t < qau_pkg::N_TERMS; t++) begin
        prod_q[t] <= $signed(op_i.m_a[t]) * $signed(op_i.m_b[t]);
      end
      neg_q       <= op_i.neg;
      prod_mode_q <= op_i.prod_mode;
      lin_q       <= $signed(op_i.lin);
    end
  end

  // stage 2: signed sum, add half an lsb, floor shift; linear ops pass lin through
  always_comb begin
    sum = '0;
    for (int t = 0; t < qau_pkg::N_TERMS; t++) begin
      if (neg_q[t]) begin
        sum = sum - qau_pkg::SUM_W'(prod_q[t]);
      end else begin
        sum = sum + qau_pkg::SUM_W'(prod_q[t]);
      end
    end
    sum_rnd = sum + qau_pkg::SUM_W'(1 << (qau_pkg::FRAC - 1));
    if (prod_mode_q) begin
      val_d = sum_rnd[qau_pkg::SUM_W-1:qau_pkg::FRAC];
    end else begin
      val_d = qau_pkg::RND_W'(lin_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule

// ===== rtl/qau_merge.sv =====
`timescale 1ns / 1ps

module qau_merge (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          valid_i,
  output logic                                          ready_o,
  input  qau_pkg::lane_vals_t                           vals_i,
  output logic                                          valid_o,
  input  logic                                          ready_i,
  output logic [qau_pkg::N_LANES-1:0][qau_pkg::QW-1:0]  r_o,
  output logic                                          overflow_o
);

  localparam logic signed [qau_pkg::RND_W-1:0] MaxExt = qau_pkg::RND_W'(qau_pkg::Q_MAX);
  localparam logic signed [qau_pkg::RND_W-1:0] MinExt = qau_pkg::RND_W'(qau_pkg::Q_MIN);

  logic [qau_pkg::N_LANES-1:0][qau_pkg::QW-1:0] r_d, r_q;
  logic [qau_pkg::N_LANES-1:0]                  sat;
  logic                                         valid_q;
  logic                                         ovf_q;

  always_comb begin
    for (int c = 0; c < qau_pkg::N_LANES; c++) begin
      if ($signed(vals_i[c]) > MaxExt) begin
        r_d[c] = qau_pkg::Q_MAX;
        sat[c] = 1'b1;
      end else if ($signed(vals_i[c]) < MinExt) begin
        r_d[c] = qau_pkg::Q_MIN;
        sat[c] = 1'b1;
      end else begin
        r_d[c] = vals_i[c][qau_pkg::QW-1:0];
        sat[c] = 1'b0;
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      r_q   <= r_d;
      ovf_q <= |sat;
    end
  end

  assign valid_o    = valid_q;
  assign r_o        = r_q;
  assign overflow_o = ovf_q;

endmodule

// ===== rtl/quaternion_arithmetic_unit.sv =====
`timescale 1ns / 1ps

// Quaternion ALU in signed Q16.16: add, subtract, Hamilton product a*b, scale
// of a by a factor, and conjugate of a, one opcode per transfer. Products are
// exact at 64 bits, summed exactly, rounded to nearest (half an lsb added,
// floor shift) and every component saturates to 32 bits; overflow in tuser
// flags any saturated component. Undefined opcodes give zero with no
// overflow. The block accepts one transfer per clock while m_axis_tready or
// an empty stage lets it advance, and returns results in order: stage one is
// four 32x32 multipliers in each of the four component lanes, stage two the
// lane's signed sum and rounding, stage three the saturation and merge into
// the output register. Each stage holds its own valid bit, so an empty stage
// keeps taking input while a finished result waits on m_axis_tready.

module quaternion_arithmetic_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  // slave side
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, factor
  input  logic [2:0]   s_axis_tuser,   // opcode
  // master side
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // r_w, r_x, r_y, r_z
  output logic [0:0]   m_axis_tuser    // overflow
);

  localparam int unsigned QW = qau_pkg::QW;
  localparam int unsigned NL = qau_pkg::N_LANES;

  logic [NL-1:0][QW-1:0] a_op, b_op;
  logic [QW-1:0]         factor;
  qau_pkg::lane_ops_t    lane_ops;
  qau_pkg::lane_vals_t   lane_vals;
  logic [NL-1:0][QW-1:0] r_out;

  // pipeline control: a stage advances when it is empty or the next one moves
  logic v1_q, v2_q;
  logic rdy1, rdy2, rdy3;

  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= s_axis_tvalid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  // unpack tdata, first field in the lowest bits
  always_comb begin
    for (int c = 0; c < NL; c++) begin
      a_op[c] = s_axis_tdata[c*QW +: QW];
      b_op[c] = s_axis_tdata[(NL + c)*QW +: QW];
    end
  end
  assign factor = s_axis_tdata[2*NL*QW +: QW];

  // per-lane operand and sign selection
  qau_route u_route (
    .opcode_i (s_axis_tuser),
    .a_i      (a_op),
    .b_i      (b_op),
    .factor_i (factor),
    .lanes_o  (lane_ops)
  );

  // one lane per component
  for (genvar c = 0; c < NL; c++) begin : g_lane
    qau_lane u_lane (
      .clk_i    (clk_i),
      .mul_en_i (rdy1),
      .sum_en_i (rdy2),
      .op_i     (lane_ops[c]),
      .val_o    (lane_vals[c])
    );
  end

  // saturation, overflow merge and output register
  qau_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v2_q),
    .ready_o    (rdy3),
    .vals_i     (lane_vals),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .r_o        (r_out),
    .overflow_o (m_axis_tuser[0])
  );

  assign m_axis_tdata = r_out;

  // overflow only ever accompanies a component pinned at a rail
  a_ovf_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (r_out[0] == qau_pkg::Q_MAX || r_out[0] == qau_pkg::Q_MIN ||
       r_out[1] == qau_pkg::Q_MAX || r_out[1] == qau_pkg::Q_MIN ||
       r_out[2] == qau_pkg::Q_MAX || r_out[2] == qau_pkg::Q_MIN ||
       r_out[3] == qau_pkg::Q_MAX || r_out[3] == qau_pkg::Q_MIN))
    else $error("overflow set without a saturated component");

  // an empty output register never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output register");

  // stage one only holds when stage two is occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !rdy1) |-> (v2_q && m_axis_tvalid))
    else $error("pipeline stalled with a bubble downstream");

  // an unstalled transfer reaches the output through the product, sum and output registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && m_axis_tready) ##1 m_axis_tready ##1
      m_axis_tready |=> m_axis_tvalid)
    else $error("result missing after three unstalled cycles");

endmodule
